// ===== sv/barycentric_triangle_row_raster_unit_assert.svh =====
// Assertion macros for the triangle row raster unit.
// Both expect clk and arst_n in scope.
`ifndef BARYCENTRIC_TRIANGLE_ROW_RASTER_UNIT_ASSERT_SVH
`define BARYCENTRIC_TRIANGLE_ROW_RASTER_UNIT_ASSERT_SVH

// Payload under a stalled beat must not move.
`define BTRR_ASSERT_HOLD(lbl, vld, rdy, sig) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(vld && !rdy) |=> $stable(sig)) else $error("stalled beat changed");

// Whenever the condition holds, the consequence holds in the same cycle.
`define BTRR_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |-> (cons)) else $error("result rule violated");

`endif

// ===== sv/btrr_pkg.sv =====
// ----------------------------------------------------------------------------
// btrr_pkg
// Types, constants and the doubled-area function of the row raster unit.
// ----------------------------------------------------------------------------
package btrr_pkg;

	localparam int QUEUE_DEPTH = 2;

	// One classified triangle row handed from front to back
	typedef struct packed {
		logic               culled;
		logic               single;
		logic [5:0]         row;
		logic [5:0]         x0;
		logic [5:0]         x1;
		logic signed [15:0] sa;
		logic signed [15:0] sb;
		logic signed [15:0] sc;
		logic signed [6:0]  da;
		logic signed [6:0]  db;
		logic signed [6:0]  dc;
		logic [12:0]        total;
		logic [7:0]         az;
		logic [7:0]         bz;
		logic [7:0]         cz;
	} job_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_COL  = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_EMIT = 4'b1000
	} back_state_t;

	// Doubled signed area of triangle (a, b, c)
	function automatic logic signed [15:0] area2(
		input logic [5:0] ax, input logic [5:0] ay,
		input logic [5:0] bx, input logic [5:0] by,
		input logic [5:0] cx, input logic [5:0] cy);
		logic signed [7:0]  d0, d1, d2;
		logic signed [7:0]  s0, s1, s2;
		logic signed [15:0] p0, p1, p2;
		d0 = signed'({2'b0, by}) - signed'({2'b0, ay});
		d1 = signed'({2'b0, cy}) - signed'({2'b0, by});
		d2 = signed'({2'b0, ay}) - signed'({2'b0, cy});
		s0 = signed'({1'b0, 7'({1'b0, bx} + {1'b0, ax})});
		s1 = signed'({1'b0, 7'({1'b0, cx} + {1'b0, bx})});
		s2 = signed'({1'b0, 7'({1'b0, ax} + {1'b0, cx})});
		p0 = 16'(d0 * s0);
		p1 = 16'(d1 * s1);
		p2 = 16'(d2 * s2);
		return p0 + p1 + p2;
	endfunction

endpackage

// ===== sv/btrr_queue.sv =====
// ----------------------------------------------------------------------------
// btrr_queue
// Two-entry job queue between the classifying front and the column walker.
// ----------------------------------------------------------------------------
module btrr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_valid,
	output logic           wr_ready,
	input  btrr_pkg::job_t wr_job,
	output logic           rd_valid,
	input  logic           rd_ready,
	output btrr_pkg::job_t rd_job
);
	import btrr_pkg::*;

	job_t       mem_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign wr_ready = (count_q != 2'(QUEUE_DEPTH));
	assign rd_valid = (count_q != 2'd0);
	assign rd_job   = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Store job
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end
endmodule

// ===== sv/btrr_front.sv =====
// ----------------------------------------------------------------------------
// btrr_front
// Two-stage front: area and bounding box, then start edge values per job.
// ----------------------------------------------------------------------------
module btrr_front #(
	parameter int SCREEN_WIDTH  = 64,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic [5:0]     vertex_a_x,
	input  logic [5:0]     vertex_a_y,
	input  logic [7:0]     vertex_a_depth,
	input  logic [5:0]     vertex_b_x,
	input  logic [5:0]     vertex_b_y,
	input  logic [7:0]     vertex_b_depth,
	input  logic [5:0]     vertex_c_x,
	input  logic [5:0]     vertex_c_y,
	input  logic [7:0]     vertex_c_depth,
	input  logic [5:0]     scan_row,
	output logic           job_valid,
	input  logic           job_ready,
	output btrr_pkg::job_t job
);
	import btrr_pkg::*;

	localparam logic [5:0] XLim = 6'(SCREEN_WIDTH - 1);

	logic              valid_s1, valid_s2, adv1, adv2;
	logic [5:0]        ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1, row_s1;
	logic [7:0]        az_s1, bz_s1, cz_s1;
	logic [5:0]        ax_s2, ay_s2, bx_s2, by_s2, cx_s2, cy_s2, row_s2;
	logic [7:0]        az_s2, bz_s2, cz_s2;
	logic [5:0]        x0_s2, x1_s2;
	logic [12:0]       total_s2;
	logic              culled_s2, single_s2;
	logic signed [15:0] total;
	logic [5:0]        x0, x1, x1c, y0, y1, m0, m1;
	logic              outside;

	assign adv2     = valid_s2 && job_ready;
	assign adv1     = valid_s1 && (!valid_s2 || adv2);
	assign in_ready = !valid_s1 || adv1;

	// Stage 1: area, bounding box and row test
	always_comb begin
		total   = area2(ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1);
		m0      = (ax_s1 < bx_s1) ? ax_s1 : bx_s1;
		x0      = (m0 < cx_s1) ? m0 : cx_s1;
		m1      = (ax_s1 > bx_s1) ? ax_s1 : bx_s1;
		x1      = (m1 > cx_s1) ? m1 : cx_s1;
		y0      = (ay_s1 < by_s1) ? ((ay_s1 < cy_s1) ? ay_s1 : cy_s1)
		                          : ((by_s1 < cy_s1) ? by_s1 : cy_s1);
		y1      = (ay_s1 > by_s1) ? ((ay_s1 > cy_s1) ? ay_s1 : cy_s1)
		                          : ((by_s1 > cy_s1) ? by_s1 : cy_s1);
		x1c     = (x1 > XLim) ? XLim : x1;
		outside = (row_s1 < y0) || (row_s1 > y1) ||
		          ({26'd0, row_s1} >= 32'(SCREEN_HEIGHT)) || (x0 > x1c);
	end

	// Capture input beat
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ax_s1 <= vertex_a_x; ay_s1 <= vertex_a_y; az_s1 <= vertex_a_depth;
			bx_s1 <= vertex_b_x; by_s1 <= vertex_b_y; bz_s1 <= vertex_b_depth;
			cx_s1 <= vertex_c_x; cy_s1 <= vertex_c_y; cz_s1 <= vertex_c_depth;
			row_s1 <= scan_row;
		end
		if (adv1) begin
			ax_s2 <= ax_s1; ay_s2 <= ay_s1; az_s2 <= az_s1;
			bx_s2 <= bx_s1; by_s2 <= by_s1; bz_s2 <= bz_s1;
			cx_s2 <= cx_s1; cy_s2 <= cy_s1; cz_s2 <= cz_s1;
			row_s2    <= row_s1;
			x0_s2     <= x0;
			x1_s2     <= x1c;
			total_s2  <= total[12:0];
			culled_s2 <= (total < 16'sd2);
			single_s2 <= (total < 16'sd2) || outside;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && in_ready) valid_s1 <= 1'b1;
			else if (adv1) valid_s1 <= 1'b0;
			if (adv1) valid_s2 <= 1'b1;
			else if (adv2) valid_s2 <= 1'b0;
		end
	end

	// Stage 2: edge values at the first column and their per-column steps
	always_comb begin
		job.culled = culled_s2;
		job.single = single_s2;
		job.row    = row_s2;
		job.x0     = x0_s2;
		job.x1     = x1_s2;
		job.sa     = area2(x0_s2, row_s2, bx_s2, by_s2, cx_s2, cy_s2);
		job.sb     = area2(x0_s2, row_s2, cx_s2, cy_s2, ax_s2, ay_s2);
		job.sc     = area2(x0_s2, row_s2, ax_s2, ay_s2, bx_s2, by_s2);
		job.da     = signed'({1'b0, by_s2}) - signed'({1'b0, cy_s2});
		job.db     = signed'({1'b0, cy_s2}) - signed'({1'b0, ay_s2});
		job.dc     = signed'({1'b0, ay_s2}) - signed'({1'b0, by_s2});
		job.total  = total_s2;
		job.az     = az_s2;
		job.bz     = bz_s2;
		job.cz     = cz_s2;
	end
	assign job_valid = valid_s2;
endmodule

// ===== sv/btrr_back.sv =====
// ----------------------------------------------------------------------------
// btrr_back
// Column walker: edge test per column, radix-2 depth divide, result register.
// ----------------------------------------------------------------------------
module btrr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_valid,
	output logic           job_ready,
	input  btrr_pkg::job_t job,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [5:0]     pixel_x,
	output logic [5:0]     pixel_y,
	output logic [7:0]     depth,
	output logic           covered,
	output logic           culled,
	output logic           last
);
	import btrr_pkg::*;

	back_state_t        state_q;
	job_t               job_q;
	logic [5:0]         x_q;
	logic signed [15:0] sa_q, sb_q, sc_q;
	logic               cov_q;
	logic [20:0]        rem_q;
	logic [19:0]        dvs_q;
	logic [7:0]         quo_q;
	logic [2:0]         cnt_q;
	logic               out_valid_q;
	logic               slot_free;
	logic               col_cov;
	logic               col_last;
	logic [20:0]        num;
	logic               ge;

	assign job_ready = (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || out_ready;
	assign col_cov   = !sa_q[15] && !sb_q[15] && !sc_q[15];
	assign col_last  = job_q.single || (x_q == job_q.x1);
	assign num       = 21'(sa_q[12:0] * job_q.az) + 21'(sb_q[12:0] * job_q.bz)
	                 + 21'(sc_q[12:0] * job_q.cz);
	assign ge        = (rem_q >= {1'b0, dvs_q});
	assign out_valid = out_valid_q;

	// Walk columns of the current job
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (job_valid) state_q <= job.single ? ST_EMIT : ST_COL;
				ST_COL:  state_q <= col_cov ? ST_DIV : ST_EMIT;
				ST_DIV:  if (cnt_q == 3'd0) state_q <= ST_EMIT;
				ST_EMIT: if (slot_free) state_q <= col_last ? ST_IDLE : ST_COL;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				job_q <= job;
				x_q   <= job.x0;
				sa_q  <= job.sa;
				sb_q  <= job.sb;
				sc_q  <= job.sc;
				cov_q <= 1'b0;
			end
			ST_COL: begin
				cov_q <= col_cov;
				rem_q <= num;
				dvs_q <= {job_q.total, 7'd0};
				quo_q <= 8'd0;
				cnt_q <= 3'd7;
			end
			ST_DIV: begin
				if (ge) rem_q <= rem_q - {1'b0, dvs_q};
				quo_q <= {quo_q[6:0], ge};
				dvs_q <= {1'b0, dvs_q[19:1]};
				cnt_q <= cnt_q - 3'd1;
			end
			ST_EMIT: begin
				if (slot_free && !col_last) begin
					x_q  <= x_q + 6'd1;
					sa_q <= sa_q + 16'(job_q.da);
					sb_q <= sb_q + 16'(job_q.db);
					sc_q <= sc_q + 16'(job_q.dc);
				end
			end
			default: begin
			end
		endcase
	end

	// Load result register
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && slot_free) begin
			pixel_x <= job_q.single ? 6'd0 : x_q;
			pixel_y <= job_q.row;
			depth   <= cov_q ? quo_q : 8'd0;
			covered <= cov_q;
			culled  <= job_q.culled;
			last    <= col_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end
endmodule

// ===== sv/barycentric_triangle_row_raster_unit.sv =====
// ----------------------------------------------------------------------------
// barycentric_triangle_row_raster_unit
// Rasterizes one screen row of one triangle with barycentric depth.
// ----------------------------------------------------------------------------
// Usage: the input channel takes one triangle (three vertices with column,
// row and depth) plus a scan row per beat. The output channel returns one
// beat per column of the clipped bounding box on that row, last set on the
// final one; a culled triangle or a row outside the box returns a single
// uncovered beat. Edge values step incrementally along the row.
// Flow: two front stages and the queue, then per column an edge test and,
// for a covered pixel only, the eight-step radix-2 depth divider, which
// dominates the walk. Single-beat items go from the queue straight to the
// result register without walking any column.
// The front accepts further items into its two-entry queue while the walker
// is busy. A stalled receiver holds the result register and the walker
// waits on it. Reset empties all stages; nothing needs clearing.
// ----------------------------------------------------------------------------
module barycentric_triangle_row_raster_unit #(
	parameter int SCREEN_WIDTH  = 64,
	parameter int SCREEN_HEIGHT = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [5:0] vertex_a_x,
	input  logic [5:0] vertex_a_y,
	input  logic [7:0] vertex_a_depth,
	input  logic [5:0] vertex_b_x,
	input  logic [5:0] vertex_b_y,
	input  logic [7:0] vertex_b_depth,
	input  logic [5:0] vertex_c_x,
	input  logic [5:0] vertex_c_y,
	input  logic [7:0] vertex_c_depth,
	input  logic [5:0] scan_row,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [5:0] pixel_x,
	output logic [5:0] pixel_y,
	output logic [7:0] depth,
	output logic       covered,
	output logic       culled,
	output logic       last
);
	import btrr_pkg::*;

	job_t fq_job, qb_job;
	logic fq_valid, fq_ready, qb_valid, qb_ready;

	btrr_front #(
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) u_front (
		.clk, .arst_n, .in_valid, .in_ready,
		.vertex_a_x, .vertex_a_y, .vertex_a_depth,
		.vertex_b_x, .vertex_b_y, .vertex_b_depth,
		.vertex_c_x, .vertex_c_y, .vertex_c_depth,
		.scan_row,
		.job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
	);

	btrr_queue u_queue (
		.clk, .arst_n,
		.wr_valid(fq_valid), .wr_ready(fq_ready), .wr_job(fq_job),
		.rd_valid(qb_valid), .rd_ready(qb_ready), .rd_job(qb_job)
	);

	btrr_back u_back (
		.clk, .arst_n,
		.job_valid(qb_valid), .job_ready(qb_ready), .job(qb_job),
		.out_valid, .out_ready,
		.pixel_x, .pixel_y, .depth, .covered, .culled, .last
	);
endmodule

// ===== sv/btrr_checker.sv =====
// ----------------------------------------------------------------------------
// btrr_checker
// Port-level checks of the row raster unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "barycentric_triangle_row_raster_unit_assert.svh"

module btrr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [5:0] pixel_x,
	input logic [7:0] depth,
	input logic       covered,
	input logic       culled,
	input logic       last
);
	// Hold a stalled result beat
	`BTRR_ASSERT_HOLD(a_out_hold, out_valid, out_ready, {pixel_x, depth, covered, culled, last})
	// Uncovered pixels carry no depth
	`BTRR_ASSERT_IMPL(a_uncov_depth, out_valid && !covered, depth == 8'd0)
	// A culled triangle gives one uncovered beat at column zero
	`BTRR_ASSERT_IMPL(a_cull_shape, out_valid && culled, last && !covered && pixel_x == 6'd0)
	// A covered pixel never comes from a culled triangle
	`BTRR_ASSERT_IMPL(a_cov_not_cull, out_valid && covered, !culled)
endmodule

bind barycentric_triangle_row_raster_unit btrr_checker u_checker (
	.clk, .arst_n, .out_valid, .out_ready,
	.pixel_x, .depth, .covered, .culled, .last
);
